[rtl/lcar_pkg.sv]
// ----------------------------------------------------------------------------
// lcar_pkg
// shared types and constants of the load cell converter reader
// ----------------------------------------------------------------------------
package lcar_pkg;

   localparam int DATA_BITS   = 24;
   localparam int DUMMY_TRIES = 3;

   localparam logic [1:0] REQ_TICK    = 2'd0;
   localparam logic [1:0] REQ_INIT    = 2'd1;
   localparam logic [1:0] REQ_MEASURE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_DUMMY_TO  = 2'd1;
   localparam logic [1:0] ST_READ_TO   = 2'd2;
   localparam logic [1:0] ST_ZERO_CNT  = 2'd3;

   localparam logic [2:0] REG_GAIN    = 3'd0;
   localparam logic [2:0] REG_HALF    = 3'd1;
   localparam logic [2:0] REG_POLL    = 3'd2;
   localparam logic [2:0] REG_TIMEOUT = 3'd3;
   localparam logic [2:0] REG_RSTHI   = 3'd4;
   localparam logic [2:0] REG_SETTLE  = 3'd5;
   localparam logic [2:0] REG_SCALE   = 3'd6;
   localparam logic [2:0] REG_OFFSET  = 3'd7;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  sample_count;
      logic        data_pin;
   } req_type_t_type;

   typedef struct packed {
      logic               clock_pin;
      logic               busy_res;
      logic               done_res;
      logic [1:0]         status;
      logic [7:0]         failed_index;
      logic signed [23:0] average_raw;
      logic signed [31:0] scaled_weight;
      logic signed [23:0] last_raw;
   } rsp_type;

   // commands from controller to datapath
   typedef struct packed {
      logic start;       // load sum and count, begin divide
   } cmd_type;

   typedef struct packed {
      logic done;        // result registers updated
   } sts_type;

endpackage

[rtl/lcar_if.sv]
// ----------------------------------------------------------------------------
// lcar_if
// valid/ready channel carrying one item
// ----------------------------------------------------------------------------
interface lcar_if #(parameter int WIDTH = 1);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/lcar_dp.sv]
// ----------------------------------------------------------------------------
// lcar_dp
// average and scale unit: serial signed divide, multiply, shift, subtract offset, saturate
// ----------------------------------------------------------------------------
module lcar_dp #(
   parameter int CNT_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lcar_pkg::cmd_type       cmd,
   input  logic signed [31:0]      sum,
   input  logic [CNT_BITS-1:0]     count,
   input  logic [31:0]             scale_factor,
   input  logic [31:0]             tare_offset,
   output lcar_pkg::sts_type       sts,
   output logic signed [23:0]      avg,
   output logic signed [31:0]      scaled
);
   import lcar_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001, S_DIV = 4'b0010, S_MUL = 4'b0100, S_OUT = 4'b1000
   } dstate_type;

   dstate_type         state_ff, state_in;
   logic [5:0]         step_ff, step_in;
   logic [31:0]        quo_ff, quo_in;
   logic [32:0]        rem_ff, rem_in;
   logic [31:0]        den_ff, den_in;
   logic               neg_ff, neg_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [23:0] avg_ff, avg_in;
   logic signed [31:0] scaled_ff, scaled_in;
   logic [32:0]        trial;
   logic [31:0]        mag;
   logic signed [31:0] q_signed;
   logic signed [63:0] shifted;
   logic signed [64:0] v;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      neg_in    = neg_ff;
      prod_in   = prod_ff;
      avg_in    = avg_ff;
      scaled_in = scaled_ff;
      mag       = sum[31] ? 32'(-sum) : 32'(sum);
      trial     = {rem_ff[31:0], quo_ff[31]} - {1'b0, den_ff};
      q_signed  = neg_ff ? 32'(-quo_ff) : quo_ff;
      shifted   = prod_ff >>> 16;
      v         = 65'(shifted) - 65'(signed'(tare_offset));
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               quo_in   = mag;
               rem_in   = '0;
               den_in   = (count == '0) ? 32'd1 : 32'(count);
               neg_in   = sum[31];
               step_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!trial[32]) begin
               rem_in = trial;
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = {rem_ff[31:0], quo_ff[31]};
               quo_in = {quo_ff[30:0], 1'b0};
            end
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd31) state_in = S_MUL;
         end
         S_MUL: begin
            avg_in   = q_signed[23:0];
            prod_in  = 64'($signed(q_signed[23:0]) * $signed({1'b0, scale_factor}));
            state_in = S_OUT;
         end
         S_OUT: begin
            if (v > 65'sd2147483647) scaled_in = 32'h7FFF_FFFF;
            else if (v < -65'sd2147483648) scaled_in = 32'h8000_0000;
            else scaled_in = v[31:0];
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         avg_ff    <= '0;
         scaled_ff <= '0;
      end else begin
         state_ff  <= state_in;
         avg_ff    <= avg_in;
         scaled_ff <= scaled_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
   end

   assign sts.done = (state_ff == S_OUT);
   assign avg      = avg_ff;
   assign scaled   = scaled_ff;
endmodule

[rtl/lcar_ctrl.sv]
// ----------------------------------------------------------------------------
// lcar_ctrl
// per-tick sequencer: reset pulse, ready polling, bit shifting, summing
// ----------------------------------------------------------------------------
module lcar_ctrl #(
   parameter int MAX_COUNT  = 255,
   parameter int TIMER_BITS = 21
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tick,
   input  lcar_pkg::req_type_t_type tin,
   input  logic [1:0]            gain_pulses,
   input  logic [9:0]            half_period_ticks,
   input  logic [9:0]            poll_ticks,
   input  logic [19:0]           timeout_ticks,
   input  logic [11:0]           reset_high_ticks,
   input  logic [11:0]           reset_settle_ticks,
   input  lcar_pkg::sts_type     sts,
   output lcar_pkg::cmd_type     cmd,
   output logic signed [31:0]    sum,
   output logic [7:0]            count,
   output logic                  clk_level,
   output logic                  busy,
   output logic                  done,
   output logic [1:0]            status,
   output logic [7:0]            failed,
   output logic signed [23:0]    last_raw,
   output logic                  calc
);
   import lcar_pkg::*;

   typedef enum logic [7:0] {
      P_IDLE = 8'b0000_0001, P_SET_A = 8'b0000_0010, P_RST_HI = 8'b0000_0100,
      P_SET_B = 8'b0000_1000, P_WAIT = 8'b0001_0000, P_CLK_HI = 8'b0010_0000,
      P_CLK_LO = 8'b0100_0000, P_CALC = 8'b1000_0000
   } phase_type;

   typedef enum logic [3:0] {
      G_INIT = 4'b0001, G_DUMMY = 4'b0010, G_READ = 4'b0100, G_FAULT = 4'b1000
   } stage_type;

   phase_type              phase_ff, phase_in;
   stage_type              stage_ff, stage_in;
   logic [11:0]            timer_ff, timer_in;
   logic [TIMER_BITS-1:0]  budget_ff, budget_in;
   logic [4:0]             bits_ff, bits_in;
   logic [23:0]            shift_ff, shift_in;
   logic signed [31:0]     sum_ff, sum_in;
   logic [7:0]             idx_ff, idx_in;
   logic [7:0]             target_ff, target_in;
   logic [1:0]             tries_ff, tries_in;
   logic                   seen_ff, seen_in;
   logic [1:0]             status_ff, status_in;
   logic [7:0]             failed_ff, failed_in;
   logic signed [23:0]     last_ff, last_in;
   logic                   done_ff, done_in;
   logic                   clk_ff, clk_in;
   logic                   start_ff, start_in;
   logic [11:0]            half1, poll1, rsthi1, settle1;
   logic [9:0]             poll_b;
   logic [7:0]             cnt_cut;
   logic [5:0]             total_bits;
   logic [7:0]             idx_next;

   always_comb begin
      half1   = (half_period_ticks == '0) ? 12'd0 : 12'(half_period_ticks - 10'd1);
      poll1   = (poll_ticks == '0) ? 12'd0 : 12'(poll_ticks - 10'd1);
      rsthi1  = (reset_high_ticks == '0) ? 12'd0 : reset_high_ticks - 12'd1;
      settle1 = (reset_settle_ticks == '0) ? 12'd0 : reset_settle_ticks - 12'd1;
      poll_b  = (poll_ticks == '0) ? 10'd1 : poll_ticks;
      cnt_cut = (32'(tin.sample_count) > MAX_COUNT) ? 8'(MAX_COUNT) : tin.sample_count;
      total_bits = 6'(DATA_BITS) + 6'(gain_pulses);
      idx_next   = idx_ff + 8'd1;
   end

   always_comb begin
      phase_in  = phase_ff;
      stage_in  = stage_ff;
      timer_in  = timer_ff;
      budget_in = budget_ff;
      bits_in   = bits_ff;
      shift_in  = shift_ff;
      sum_in    = sum_ff;
      idx_in    = idx_ff;
      target_in = target_ff;
      tries_in  = tries_ff;
      seen_in   = seen_ff;
      status_in = status_ff;
      failed_in = failed_ff;
      last_in   = last_ff;
      done_in   = done_ff;
      clk_in    = clk_ff;
      start_in  = 1'b0;
      if (phase_ff == P_CALC) begin
         if (sts.done) begin
            phase_in  = P_IDLE;
            status_in = ST_OK;
            failed_in = '0;
            done_in   = 1'b1;
         end
      end else if (tick) begin
         clk_in  = (phase_ff == P_RST_HI) || (phase_ff == P_CLK_HI);
         done_in = 1'b0;
         unique case (phase_ff)
            P_IDLE: begin
               if (tin.req_type == REQ_INIT) begin
                  stage_in = G_INIT;
                  phase_in = P_SET_A;
                  timer_in = settle1;
               end else if (tin.req_type == REQ_MEASURE) begin
                  target_in = cnt_cut;
                  if (cnt_cut == '0) begin
                     status_in = ST_ZERO_CNT;
                     failed_in = '0;
                     done_in   = 1'b1;
                  end else begin
                     stage_in  = G_DUMMY;
                     tries_in  = '0;
                     phase_in  = P_WAIT;
                     timer_in  = '0;
                     budget_in = TIMER_BITS'(timeout_ticks);
                     seen_in   = 1'b0;
                  end
               end
            end
            P_WAIT: begin
               if (timer_ff != '0) begin
                  timer_in = timer_ff - 12'd1;
               end else if (budget_ff == '0) begin
                  if (stage_ff == G_READ) begin
                     failed_in = idx_next;
                     stage_in  = G_FAULT;
                     phase_in  = P_SET_A;
                     timer_in  = settle1;
                  end else begin
                     bits_in  = '0;
                     shift_in = '0;
                     phase_in = P_CLK_HI;
                     timer_in = half1;
                  end
               end else if (!tin.data_pin) begin
                  seen_in  = 1'b1;
                  bits_in  = '0;
                  shift_in = '0;
                  phase_in = P_CLK_HI;
                  timer_in = half1;
               end else begin
                  budget_in = (34'(budget_ff) > 34'(poll_b)) ?
                              TIMER_BITS'(34'(budget_ff) - 34'(poll_b)) : '0;
                  timer_in  = poll1;
               end
            end
            P_SET_A, P_RST_HI, P_SET_B, P_CLK_HI, P_CLK_LO: begin
               if (timer_ff != '0) begin
                  timer_in = timer_ff - 12'd1;
               end else begin
                  unique case (phase_ff)
                     P_SET_A: begin
                        phase_in = P_RST_HI;
                        timer_in = rsthi1;
                     end
                     P_RST_HI: begin
                        phase_in = P_SET_B;
                        timer_in = settle1;
                     end
                     P_SET_B: begin
                        if (stage_ff == G_INIT) begin
                           phase_in  = P_WAIT;
                           timer_in  = '0;
                           budget_in = TIMER_BITS'(timeout_ticks);
                           seen_in   = 1'b0;
                        end else begin
                           phase_in  = P_IDLE;
                           status_in = ST_READ_TO;
                           done_in   = 1'b1;
                        end
                     end
                     P_CLK_HI: begin
                        if (32'(bits_ff) < DATA_BITS)
                           shift_in = {shift_ff[22:0], tin.data_pin};
                        phase_in = P_CLK_LO;
                        timer_in = half1;
                     end
                     default: begin
                        bits_in = bits_ff + 5'd1;
                        if (6'(bits_in) < total_bits) begin
                           phase_in = P_CLK_HI;
                           timer_in = half1;
                        end else begin
                           last_in = signed'(shift_ff);
                           if (stage_ff == G_INIT) begin
                              phase_in  = P_IDLE;
                              status_in = ST_OK;
                              failed_in = '0;
                              done_in   = 1'b1;
                           end else if (stage_ff == G_DUMMY) begin
                              phase_in  = P_WAIT;
                              timer_in  = '0;
                              budget_in = TIMER_BITS'(timeout_ticks);
                              if (seen_ff) begin
                                 stage_in = G_READ;
                                 idx_in   = '0;
                                 sum_in   = '0;
                              end else if (32'(tries_ff) < DUMMY_TRIES - 1) begin
                                 tries_in = tries_ff + 2'd1;
                              end else begin
                                 phase_in  = P_IDLE;
                                 status_in = ST_DUMMY_TO;
                                 failed_in = '0;
                                 done_in   = 1'b1;
                              end
                              seen_in = 1'b0;
                           end else begin
                              sum_in = sum_ff + 32'(signed'(shift_ff));
                              idx_in = idx_next;
                              if (idx_next >= target_ff) begin
                                 phase_in = P_CALC;
                                 start_in = 1'b1;
                              end else begin
                                 phase_in  = P_WAIT;
                                 timer_in  = '0;
                                 budget_in = TIMER_BITS'(timeout_ticks);
                                 seen_in   = 1'b0;
                              end
                           end
                        end
                     end
                  endcase
               end
            end
            default: phase_in = P_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= P_IDLE;
         stage_ff  <= G_INIT;
         timer_ff  <= '0;
         budget_ff <= '0;
         bits_ff   <= '0;
         shift_ff  <= '0;
         sum_ff    <= '0;
         idx_ff    <= '0;
         target_ff <= '0;
         tries_ff  <= '0;
         seen_ff   <= 1'b0;
         status_ff <= ST_OK;
         failed_ff <= '0;
         last_ff   <= '0;
         done_ff   <= 1'b0;
         clk_ff    <= 1'b0;
         start_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         stage_ff  <= stage_in;
         timer_ff  <= timer_in;
         budget_ff <= budget_in;
         bits_ff   <= bits_in;
         shift_ff  <= shift_in;
         sum_ff    <= sum_in;
         idx_ff    <= idx_in;
         target_ff <= target_in;
         tries_ff  <= tries_in;
         seen_ff   <= seen_in;
         status_ff <= status_in;
         failed_ff <= failed_in;
         last_ff   <= last_in;
         done_ff   <= done_in;
         clk_ff    <= clk_in;
         start_ff  <= start_in;
      end
   end

   assign cmd.start = start_ff;
   assign sum       = sum_ff;
   assign count     = target_ff;
   assign clk_level = clk_ff;
   assign busy      = (phase_ff != P_IDLE);
   assign done      = done_ff;
   assign status    = status_ff;
   assign failed    = failed_ff;
   assign last_raw  = last_ff;
   assign calc      = (phase_ff == P_CALC);
endmodule

[rtl/load_cell_adc_reader_averager.sv]
// ----------------------------------------------------------------------------
// load_cell_adc_reader_averager
// two-wire load cell converter reader with averaging and scaling
//
//   channel  dir  payload
//   req      in   req_type, sample_count, data_pin (one tick)
//   rsp      out  clock_pin .. last_raw (one per tick)
//   csr      in   wr_en, index, 32-bit data
//
// a tick steps the sequencer; the item is then formed in the output register
// and handed over on rsp
// the tick that ends a measurement also waits for the serial 32-step
// divider, the multiplier and the saturating subtract in the datapath
// synchronous reset returns to idle with default register values
// a stalled rsp item holds the sequencer; no new tick is taken until it leaves
// ----------------------------------------------------------------------------
module load_cell_adc_reader_averager #(
   parameter int MAX_COUNT  = 255,
   parameter int TIMER_BITS = 21
) (
   input  logic        clock,
   input  logic        reset,
   lcar_if.sink        req,
   lcar_if.source      rsp,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import lcar_pkg::*;

   logic [1:0]  gain_ff;
   logic [9:0]  half_ff, poll_ff;
   logic [19:0] tmo_ff;
   logic [11:0] rsthi_ff, settle_ff;
   logic [31:0] scale_ff, offset_ff;
   logic        hold_ff, hold_in;
   logic        pend_ff, pend_in;
   rsp_type     out_ff, out_in;
   logic        tick, calc, busy, done, clk_level;
   logic [1:0]  status;
   logic [7:0]  failed, count;
   logic signed [23:0] last_raw, avg;
   logic signed [31:0] sum, scaled;
   cmd_type     cmd;
   sts_type     sts;
   req_type_t_type tin;

   assign tin     = req.data;
   assign req.ready = !hold_ff && !pend_ff && !calc;
   assign tick    = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= 2'd3;
         half_ff   <= 10'd10;
         poll_ff   <= 10'd25;
         tmo_ff    <= 20'd200000;
         rsthi_ff  <= 12'd200;
         settle_ff <= 12'd500;
         scale_ff  <= 32'd2147484;
         offset_ff <= 32'd0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_GAIN:    gain_ff   <= csr_data[1:0];
            REG_HALF:    half_ff   <= csr_data[9:0];
            REG_POLL:    poll_ff   <= csr_data[9:0];
            REG_TIMEOUT: tmo_ff    <= csr_data[19:0];
            REG_RSTHI:   rsthi_ff  <= csr_data[11:0];
            REG_SETTLE:  settle_ff <= csr_data[11:0];
            REG_SCALE:   scale_ff  <= csr_data;
            REG_OFFSET:  offset_ff <= csr_data;
            default: ;
         endcase
      end
   end

   lcar_ctrl #(.MAX_COUNT(MAX_COUNT), .TIMER_BITS(TIMER_BITS)) u_ctrl (
      .clock, .reset, .tick, .tin,
      .gain_pulses(gain_ff), .half_period_ticks(half_ff), .poll_ticks(poll_ff),
      .timeout_ticks(tmo_ff), .reset_high_ticks(rsthi_ff),
      .reset_settle_ticks(settle_ff), .sts, .cmd, .sum, .count, .clk_level,
      .busy, .done, .status, .failed, .last_raw, .calc
   );

   lcar_dp #(.CNT_BITS(8)) u_dp (
      .clock, .reset, .cmd, .sum, .count, .scale_factor(scale_ff),
      .tare_offset(offset_ff), .sts, .avg, .scaled
   );

   // pend: a tick was stepped, item is formed next cycle unless calc runs
   always_comb begin
      pend_in = pend_ff;
      hold_in = hold_ff;
      out_in  = out_ff;
      if (hold_ff && rsp.ready) hold_in = 1'b0;
      if (tick) pend_in = 1'b1;
      if (pend_ff && !calc) begin
         pend_in               = 1'b0;
         hold_in               = 1'b1;
         out_in.clock_pin      = clk_level;
         out_in.busy_res       = busy;
         out_in.done_res       = done;
         out_in.status         = status;
         out_in.failed_index   = failed;
         out_in.average_raw    = avg;
         out_in.scaled_weight  = scaled;
         out_in.last_raw       = last_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         hold_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         hold_ff <= hold_in;
      end
      out_ff <= out_in;
   end

   assign rsp.valid = hold_ff;
   assign rsp.data  = out_ff;
endmodule
